/* sv/ptpff_pkg.sv */
// Shared types and constants for the page table protect / first-fit block.
`default_nettype none
package ptpff_pkg;

  localparam int PAGE_W  = 10;
  localparam int PERM_W  = 3;
  localparam int TYPE_W  = 4;
  localparam int FLAGS_W = 8;
  localparam int LEN_W   = 11;
  localparam int WORD_W  = TYPE_W + FLAGS_W;

  // page type codes
  localparam logic [TYPE_W-1:0] T_INVALID  = 4'd0;
  localparam logic [TYPE_W-1:0] T_ONDEMAND = 4'd1;
  localparam logic [TYPE_W-1:0] T_FILE     = 4'd2;
  localparam logic [TYPE_W-1:0] T_RO       = 4'd3;
  localparam logic [TYPE_W-1:0] T_RW       = 4'd4;
  localparam logic [TYPE_W-1:0] T_WO       = 4'd5;
  localparam logic [TYPE_W-1:0] T_NO       = 4'd6;
  localparam logic [TYPE_W-1:0] T_COW      = 4'd7;
  localparam logic [TYPE_W-1:0] T_CODE     = 4'd8;
  localparam logic [TYPE_W-1:0] T_NATIVE   = 4'd9;

  localparam int PERM_READ_BIT  = 0;
  localparam int PERM_WRITE_BIT = 1;
  localparam int FLAG_MAPPED_BIT = 5;

  typedef enum logic [1:0] {
    CMD_PROTECT = 2'd0,
    CMD_INSTALL = 2'd1,
    CMD_FIND    = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [PAGE_W-1:0]   page_index;
    logic [PERM_W-1:0]   perm_bits;
    logic [TYPE_W-1:0]   new_type;
    logic [FLAGS_W-1:0]  new_flags;
    logic [PAGE_W-1:0]   start_page;
    logic [LEN_W-1:0]    run_length;
    logic                allow_remap;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [PAGE_W-1:0]   found_page;
    logic [TYPE_W-1:0]   page_type;
    logic [FLAGS_W-1:0]  page_flags;
    logic                allocated;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic exec;
    logic rmw;
    logic scan;
    logic resp_load;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    cmd_e cmd;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* sv/ptpff_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptpff_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* sv/ptpff_ctrl.sv */
// Sequencing state machine for the page table block.
`default_nettype none
module ptpff_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ptpff_pkg::stat_t stat_i,
  output ptpff_pkg::ctrl_t    ctrl_o
);

  ptpff_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptpff_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ptpff_pkg::ST_CLEAR: begin
        ctrl_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ptpff_pkg::ST_IDLE;
        end
      end
      ptpff_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ptpff_pkg::ST_EXEC;
        end
      end
      ptpff_pkg::ST_EXEC: begin
        ctrl_o.exec = 1'b1;
        unique case (stat_i.cmd)
          ptpff_pkg::CMD_PROTECT,
          ptpff_pkg::CMD_QUERY:   state_d = ptpff_pkg::ST_WAIT;
          ptpff_pkg::CMD_INSTALL: state_d = ptpff_pkg::ST_RESP;
          ptpff_pkg::CMD_FIND:    state_d = ptpff_pkg::ST_SCAN;
          default:                state_d = ptpff_pkg::ST_RESP;
        endcase
      end
      ptpff_pkg::ST_WAIT: begin
        ctrl_o.rmw = 1'b1;
        state_d    = ptpff_pkg::ST_RESP;
      end
      ptpff_pkg::ST_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ptpff_pkg::ST_RESP;
        end
      end
      ptpff_pkg::ST_RESP: begin
        if (stat_i.out_free) begin
          ctrl_o.resp_load = 1'b1;
          state_d          = ptpff_pkg::ST_IDLE;
        end
      end
      default: state_d = ptpff_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/ptpff_dp.sv */
// Datapath: page table RAM, protect merge, run scan and result registers.
`default_nettype none
module ptpff_dp #(
  parameter int NUM_PAGES = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ptpff_pkg::ctrl_t  ctrl_i,
  output ptpff_pkg::stat_t       stat_o,
  input  wire ptpff_pkg::req_t   req_i,
  output ptpff_pkg::res_t        res_o,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int SW = ((AW > ptpff_pkg::LEN_W) ? AW : ptpff_pkg::LEN_W) + 2;
  localparam int LW = ptpff_pkg::LEN_W;
  localparam int FW = ptpff_pkg::FLAGS_W;
  localparam int TW = ptpff_pkg::TYPE_W;
  localparam logic [SW-1:0] NUM_S  = SW'(NUM_PAGES);
  localparam logic [AW-1:0] LAST_A = AW'(NUM_PAGES - 1);

  ptpff_pkg::req_t req_q;
  ptpff_pkg::res_t res_q, out_q;
  logic            out_vld_q;
  logic [AW-1:0]   clr_q;
  logic [SW-1:0]   scan_q, ev_page_q, cand_q;
  logic            ev_vld_q;
  logic [LW-1:0]   run_q;

  // RAM ports
  logic                          we;
  logic [AW-1:0]                 waddr, raddr;
  logic [ptpff_pkg::WORD_W-1:0]  wdata, rdata;

  ptpff_ram #(
    .WIDTH (ptpff_pkg::WORD_W),
    .DEPTH (NUM_PAGES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [TW-1:0] rd_type;
  logic [FW-1:0] rd_flags;
  assign rd_type  = rdata[ptpff_pkg::WORD_W-1:FW];
  assign rd_flags = rdata[FW-1:0];

  logic [AW-1:0] idx_addr, scan_addr;
  logic          idx_ok, install_ok;
  assign idx_addr   = AW'(req_q.page_index);
  assign idx_ok     = SW'(req_q.page_index) < NUM_S;
  assign install_ok = idx_ok && (req_q.new_type <= ptpff_pkg::T_NATIVE);
  // speculative read one past the end is parked at entry 0
  assign scan_addr  = (scan_q < NUM_S) ? AW'(scan_q) : '0;

  // protect merge
  logic          p_rd, p_wr, prot_we;
  logic [TW-1:0] target, prot_type;
  logic [FW-1:0] new_fl;

  always_comb begin
    p_rd      = req_q.perm_bits[ptpff_pkg::PERM_READ_BIT];
    p_wr      = req_q.perm_bits[ptpff_pkg::PERM_WRITE_BIT];
    new_fl    = {rd_flags[FW-1:ptpff_pkg::PERM_W], req_q.perm_bits};
    target    = p_rd ? (p_wr ? ptpff_pkg::T_RW : ptpff_pkg::T_RO)
                     : (p_wr ? ptpff_pkg::T_WO : ptpff_pkg::T_NO);
    prot_we   = 1'b0;
    prot_type = rd_type;
    priority if (rd_type == ptpff_pkg::T_INVALID) begin
      prot_we   = 1'b1;
      prot_type = ptpff_pkg::T_ONDEMAND;
    end else if (rd_type == ptpff_pkg::T_RO || rd_type == ptpff_pkg::T_RW ||
                 rd_type == ptpff_pkg::T_WO || rd_type == ptpff_pkg::T_NO) begin
      prot_we   = (rd_type != target);
      prot_type = target;
    end else if (rd_type == ptpff_pkg::T_COW) begin
      prot_we   = 1'b1;
      prot_type = p_rd ? ptpff_pkg::T_COW : target;
    end else if (rd_type == ptpff_pkg::T_ONDEMAND || rd_type == ptpff_pkg::T_FILE ||
                 rd_type == ptpff_pkg::T_CODE) begin
      prot_we = 1'b1;
    end else begin
      prot_we = 1'b0;  // native and undefined types stay untouched
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_addr;
    wdata = '0;
    raddr = ctrl_i.scan ? scan_addr : idx_addr;
    priority if (ctrl_i.clr_step) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (ctrl_i.exec && req_q.cmd == ptpff_pkg::CMD_INSTALL && install_ok) begin
      we    = 1'b1;
      wdata = {req_q.new_type, req_q.new_flags};
    end else if (ctrl_i.rmw && req_q.cmd == ptpff_pkg::CMD_PROTECT && idx_ok && prot_we) begin
      we    = 1'b1;
      wdata = {prot_type, new_fl};
    end else begin
      we = 1'b0;
    end
  end

  // run scan evaluation on the page whose data just came back
  logic pg_free, bound_fail, eval, found, failed, len_le1, run_hit;
  logic [SW-1:0] found_page;

  always_comb begin
    pg_free    = (rd_type == ptpff_pkg::T_INVALID) ||
                 (req_q.allow_remap && rd_flags[ptpff_pkg::FLAG_MAPPED_BIT]);
    bound_fail = (ev_page_q + SW'(req_q.run_length)) >= NUM_S;
    eval       = ctrl_i.scan && ev_vld_q;
    len_le1    = req_q.run_length <= LW'(1);
    run_hit    = LW'(run_q + 1'b1) == req_q.run_length;
    failed     = eval && (run_q == '0) && bound_fail;
    if (run_q == '0) begin
      found = eval && !bound_fail && pg_free && len_le1;
    end else begin
      found = eval && pg_free && run_hit;
    end
    found_page = (run_q == '0) ? ev_page_q : cand_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      ev_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      run_q     <= '0;
    end else begin
      if (ctrl_i.clr_step) begin
        clr_q <= AW'(clr_q + 1'b1);
      end
      if (ctrl_i.exec) begin
        ev_vld_q <= 1'b0;
        run_q    <= '0;
      end else if (ctrl_i.scan) begin
        ev_vld_q <= 1'b1;
        if (eval) begin
          if (run_q == '0) begin
            if (!bound_fail && pg_free) begin
              run_q <= LW'(1);
            end
          end else if (pg_free) begin
            run_q <= LW'(run_q + 1'b1);
          end else begin
            run_q <= '0;  // next page becomes the new candidate
          end
        end
      end
      if (ctrl_i.resp_load) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      req_q <= req_i;
    end
    if (ctrl_i.exec) begin
      scan_q <= SW'(req_q.start_page);
      res_q  <= '0;
    end else if (ctrl_i.scan) begin
      scan_q    <= SW'(scan_q + 1'b1);
      ev_page_q <= scan_q;
      if (eval && run_q == '0 && !bound_fail && pg_free) begin
        cand_q <= ev_page_q;
      end
      if (found || failed) begin
        res_q.status     <= failed;
        res_q.found_page <= found ? ptpff_pkg::PAGE_W'(found_page) : '0;
      end
    end else if (ctrl_i.rmw && req_q.cmd == ptpff_pkg::CMD_QUERY && idx_ok) begin
      res_q.page_type  <= rd_type;
      res_q.page_flags <= rd_flags;
      res_q.allocated  <= (rd_type != ptpff_pkg::T_INVALID);
    end
    if (ctrl_i.resp_load) begin
      out_q <= res_q;
    end
  end

  assign stat_o.clr_last  = (clr_q == LAST_A);
  assign stat_o.cmd       = req_q.cmd;
  assign stat_o.scan_done = found || failed;
  assign stat_o.out_free  = !out_vld_q || res_ready_i;

  assign res_o       = out_q;
  assign res_valid_o = out_vld_q;

endmodule
`default_nettype wire

/* sv/page_table_protect_and_first_fit_top.sv */
// Top level: page table with protect, install, first-fit run search and query.
//
// Usage:
//   One command enters per transfer on the s_axis channel; tuser carries the
//   command code, tdata its operands. Every command yields exactly one
//   transfer on the m_axis channel.
//   Commands run one at a time. Install writes its entry straight from the
//   accepted command; protect and query first read the RAM, then merge or
//   capture. Find reads one page per cycle from start_page onward and ends
//   at the first fitting run or at the table bound. The next command is
//   accepted in the cycle after the result register loads.
//   After reset the block runs a clearing pass, writing one table entry per
//   cycle to invalid/zero; s_axis_tready_o stays low.
//   The result sits in an output register; the next command is accepted
//   while it waits. A new result is held back only if that register is
//   still full when the following command finishes, so a stalled receiver
//   stalls the block without losing or repeating results.
`default_nettype none
module page_table_protect_and_first_fit_top #(
  parameter int NUM_PAGES = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [9:0] page_index, [12:10] perm_bits, [16:13] new_type, [24:17] new_flags,
  // [34:25] start_page, [45:35] run_length, [46] allow_remap, [47] zero
  input  wire logic [47:0] s_axis_tdata_i,
  // [1:0] cmd
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] status, [10:1] found_page, [14:11] page_type, [22:15] page_flags,
  // [23] allocated
  output logic [23:0]      m_axis_tdata_o
);

  ptpff_pkg::req_t  req;
  ptpff_pkg::res_t  res;
  ptpff_pkg::ctrl_t ctrl;
  ptpff_pkg::stat_t stat;

  // unpack operands
  assign req.cmd         = ptpff_pkg::cmd_e'(s_axis_tuser_i);
  assign req.page_index  = s_axis_tdata_i[9:0];
  assign req.perm_bits   = s_axis_tdata_i[12:10];
  assign req.new_type    = s_axis_tdata_i[16:13];
  assign req.new_flags   = s_axis_tdata_i[24:17];
  assign req.start_page  = s_axis_tdata_i[34:25];
  assign req.run_length  = s_axis_tdata_i[45:35];
  assign req.allow_remap = s_axis_tdata_i[46];

  ptpff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ptpff_dp #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .req_i       (req),
    .res_o       (res),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i)
  );

  // pack result, lowest field first
  assign m_axis_tdata_o = {res.allocated, res.page_flags, res.page_type,
                           res.found_page, res.status};

endmodule
`default_nettype wire
